### hdl/fltpw_pkg.sv
// Shared types and constants of the four-level page table walker.
package fltpw_pkg;

    localparam int VA_BITS    = 48;
    localparam int PA_WIDTH   = 52;
    localparam int ENTRY_BITS = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int TOP_SHIFT  = 39;
    localparam int IDX_BITS   = 9;
    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_LARGE_BIT   = 7;
    localparam logic [1:0] LAST_LEVEL = 2'd3;

    typedef enum logic [0:0] {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    // One classified word as it sits in the queue between front and back.
    typedef struct packed {
        t_op                     op;
        logic [VA_BITS-1:0]      virt_addr;
        logic [ENTRY_BITS-1:0]   entry_data;
    } t_item;

endpackage

### hdl/fltpw_in_if.sv
// Input channel: translate requests and table entry responses.
interface fltpw_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [fltpw_pkg::VA_BITS-1:0]     virt_addr;
    logic [fltpw_pkg::ENTRY_BITS-1:0]  entry_data;

    modport source (output valid, output opcode, output virt_addr, output entry_data,
                    input ready);
    modport sink (input valid, input opcode, input virt_addr, input entry_data,
                  output ready);
endinterface

### hdl/fltpw_out_if.sv
// Output channel: read requests, finished translations, faults and errors.
interface fltpw_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [fltpw_pkg::PA_WIDTH-1:0]  address;
    logic [1:0]                      level;

    modport source (output valid, output kind, output address, output level,
                    input ready);
    modport sink (input valid, input kind, input address, input level,
                  output ready);
endinterface

### hdl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker.
// The walker takes one word per cycle on i_item while the queue has room and gives
// one result word for each on o_result. A front end decodes each word into a
// two-entry queue; the back end takes one queued word per cycle while the output is
// not stalled, advances the walk state and loads the result register, so the walk
// state update in the back end sets the sustained rate of one word per cycle. A
// translate request yields a read request for the top-level entry, and each entry
// response yields the next read request, a finished translation or a not-present
// fault. A request during a walk, or a response with no walk in progress, yields a
// protocol error and leaves the walk alone. The root table base is written through
// i_cfg_we and i_cfg_data; the user must do so only while the walker is idle (the
// block does not check). Its low 12 bits and bits at or above PA_BITS are ignored.
module four_level_page_table_walker_top #(
    parameter int PA_BITS = 52
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fltpw_pkg::PA_WIDTH-1:0]  i_cfg_data,
    fltpw_in_if.sink                        i_item,
    fltpw_out_if.source                     o_result
);
    import fltpw_pkg::*;

    logic   q_valid;
    logic   q_ready;
    t_item  q_item;

    fltpw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    fltpw_back #(
        .PA_BITS (PA_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_result   (o_result)
    );

endmodule

### hdl/fltpw_front.sv
// Front end: accepts input words, decodes them and queues them for the walker.
module fltpw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fltpw_in_if.sink          i_item,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output fltpw_pkg::t_item  o_q_item
);
    import fltpw_pkg::*;

    localparam int DEPTH = 2;

    t_item      r_queue [DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_item      in_item;

    always_comb begin
        in_item.op         = t_op'(i_item.opcode);
        in_item.virt_addr  = i_item.virt_addr;
        in_item.entry_data = i_item.entry_data;
    end

    assign i_item.ready = (r_count != 2'(DEPTH));
    assign push         = i_item.valid && i_item.ready;
    assign o_q_valid    = (r_count != 2'd0);
    assign pop          = o_q_valid && i_q_ready;
    assign o_q_item     = r_queue[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

### hdl/fltpw_back.sv
// Back end: walk state, per-word walk step and the registered result word.
module fltpw_back #(
    parameter int PA_BITS = 52
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fltpw_pkg::PA_WIDTH-1:0]    i_cfg_data,
    input  logic                              i_q_valid,
    output logic                              o_q_ready,
    input  fltpw_pkg::t_item                  i_q_item,
    fltpw_out_if.source                       o_result
);
    import fltpw_pkg::*;

    localparam int FRAME_BITS = PA_BITS - PAGE_SHIFT;
    localparam logic [PA_WIDTH-1:0] PA_MASK =
        PA_WIDTH'((64'd1 << PA_BITS) - 64'd1);
    localparam logic [PA_WIDTH-1:0] FRAME_MASK =
        PA_MASK & ~PA_WIDTH'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [FRAME_BITS-1:0]  r_root_frame;
    logic                   r_busy;
    logic [1:0]             r_level;
    logic [VA_BITS-1:0]     r_vaddr;
    logic [FRAME_BITS-1:0]  r_frame;
    logic                   n_busy;
    logic [1:0]             n_level;
    logic [VA_BITS-1:0]     n_vaddr;
    logic [FRAME_BITS-1:0]  n_frame;

    logic                   r_out_valid;
    t_kind                  r_kind;
    logic [PA_WIDTH-1:0]    r_address;
    logic [1:0]             r_out_level;

    t_kind                  res_kind;
    logic [PA_WIDTH-1:0]    res_address;
    logic [1:0]             res_level;
    logic                   issue_read;
    logic [IDX_BITS-1:0]    index;
    logic [PA_WIDTH-1:0]    off_mask;
    logic [PA_WIDTH-1:0]    ent_frame;
    logic [PA_WIDTH-1:0]    phys_addr;
    logic                   pop;

    assign o_q_ready = !r_out_valid || o_result.ready;
    assign pop       = i_q_valid && o_q_ready;

    // Offset bits kept from the virtual address when the walk ends at this level.
    always_comb begin
        case (r_level)
            2'd0:    off_mask = PA_WIDTH'((64'd1 << TOP_SHIFT) - 64'd1);
            2'd1:    off_mask = PA_WIDTH'((64'd1 << (TOP_SHIFT - IDX_BITS)) - 64'd1);
            2'd2:    off_mask = PA_WIDTH'((64'd1 << (TOP_SHIFT - 2 * IDX_BITS)) - 64'd1);
            default: off_mask = PA_WIDTH'((64'd1 << PAGE_SHIFT) - 64'd1);
        endcase
    end

    assign ent_frame = i_q_item.entry_data[PA_WIDTH-1:0] & FRAME_MASK;
    assign phys_addr = ((ent_frame & ~off_mask)
                       | (PA_WIDTH'(r_vaddr) & off_mask)) & PA_MASK;

    always_comb begin
        n_busy      = r_busy;
        n_level     = r_level;
        n_vaddr     = r_vaddr;
        n_frame     = r_frame;
        res_kind    = KIND_ERROR;
        res_address = '0;
        res_level   = 2'd0;
        issue_read  = 1'b0;
        index       = '0;

        unique case (i_q_item.op)
            OP_TRANSLATE: begin
                if (r_busy) begin
                    res_level = r_level;
                end else begin
                    n_busy     = 1'b1;
                    n_level    = 2'd0;
                    n_vaddr    = i_q_item.virt_addr;
                    n_frame    = r_root_frame;
                    issue_read = 1'b1;
                end
            end
            OP_RESPONSE: begin
                if (!r_busy) begin
                    res_level = 2'd0;
                end else if (!i_q_item.entry_data[ENT_PRESENT_BIT]) begin
                    n_busy    = 1'b0;
                    res_kind  = KIND_FAULT;
                    res_level = r_level;
                end else if (i_q_item.entry_data[ENT_LARGE_BIT] || r_level == LAST_LEVEL) begin
                    n_busy      = 1'b0;
                    res_kind    = KIND_DONE;
                    res_address = phys_addr;
                    res_level   = r_level;
                end else begin
                    n_frame    = i_q_item.entry_data[PA_BITS-1:PAGE_SHIFT];
                    n_level    = r_level + 2'd1;
                    issue_read = 1'b1;
                end
            end
            default: begin
                res_level = 2'd0;
            end
        endcase

        // The read address is built from the walk state this word leaves behind.
        if (issue_read) begin
            case (n_level)
                2'd0:    index = n_vaddr[TOP_SHIFT +: IDX_BITS];
                2'd1:    index = n_vaddr[TOP_SHIFT - IDX_BITS +: IDX_BITS];
                2'd2:    index = n_vaddr[TOP_SHIFT - 2 * IDX_BITS +: IDX_BITS];
                default: index = n_vaddr[PAGE_SHIFT +: IDX_BITS];
            endcase
            res_kind    = KIND_READ;
            res_address = '0;
            res_address[PA_BITS-1:PAGE_SHIFT] = n_frame;
            res_address[PAGE_SHIFT-1:3]       = index;
            res_level   = n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
            r_busy       <= 1'b0;
            r_level      <= 2'd0;
            r_vaddr      <= '0;
            r_frame      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root_frame <= i_cfg_data[PA_BITS-1:PAGE_SHIFT];
            end
            if (pop) begin
                r_busy      <= n_busy;
                r_level     <= n_level;
                r_vaddr     <= n_vaddr;
                r_frame     <= n_frame;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind      <= res_kind;
            r_address   <= res_address;
            r_out_level <= res_level;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.kind    = r_kind;
    assign o_result.address = r_address;
    assign o_result.level   = r_out_level;

endmodule
